[hw/rtl/lae_pkg.sv]
// shared types, constants and register codes of the linear adsr envelope block
// no dependencies
package lae_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 24;
    localparam int IO_LEVEL_W          = 25;
    localparam int CFG_STEP_W          = 25;
    localparam int CFG_MODE_W          = 2;
    localparam int CFG_IDX_W           = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_MODE   = 3'd4;

    localparam logic [CFG_MODE_W-1:0] START_NORMAL      = 2'd0;
    localparam logic [CFG_MODE_W-1:0] START_SKIP_ATTACK = 2'd1;

    localparam logic [CFG_STEP_W-1:0] RST_ATTACK_STEP  = 25'd16777216;
    localparam logic [CFG_STEP_W-1:0] RST_DECAY_STEP   = 25'd16777216;
    localparam logic [CFG_STEP_W-1:0] RST_RELEASE_STEP = 25'd16777216;
    localparam logic [CFG_STEP_W-1:0] RST_HOLD_LEVEL   = 25'd8388608;
    localparam logic [CFG_MODE_W-1:0] RST_START_MODE   = START_NORMAL;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef struct packed {
        logic [CFG_STEP_W-1:0] attack_step;
        logic [CFG_STEP_W-1:0] decay_step;
        logic [CFG_STEP_W-1:0] release_step;
        logic [CFG_STEP_W-1:0] hold_level;
        logic [CFG_MODE_W-1:0] start_mode;
    } t_cfg;

    typedef struct packed {
        logic opcode;
        logic stop;
    } t_in_item;

    typedef struct packed {
        logic [IO_LEVEL_W-1:0] level;
        logic                  active;
    } t_out_item;

endpackage

[hw/rtl/lae_ifs.sv]
// valid/ready channel interfaces: command input, level output, register write
// depends on lae_pkg
interface lae_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic stop;
    modport source (output valid, output opcode, output stop, input ready);
    modport sink   (input valid, input opcode, input stop, output ready);
endinterface

interface lae_out_if;
    logic                           valid;
    logic                           ready;
    logic [lae_pkg::IO_LEVEL_W-1:0] level;
    logic                           active;
    modport source (output valid, output level, output active, input ready);
    modport sink   (input valid, input level, input active, output ready);
endinterface

interface lae_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lae_pkg::CFG_IDX_W-1:0] index;
    logic [lae_pkg::CFG_STEP_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/linear_adsr_envelope.sv]
// Linear ADSR envelope generator. Each transaction on i_in is a sample tick
// (opcode 0, optionally with stop to release the key) or a note start
// (opcode 1, restarted as the start_mode register says) and yields exactly one
// transaction on o_out carrying the new level (1.0 is 2^LEVEL_FRAC_BITS,
// masked to 25 bits) and an active flag. A new transaction is taken every
// cycle unless a held result stalls it; the level passes the input register and
// the result register around the add or subtract, compare and clamp. Registers
// are written via i_cfg, always ready, by the user only while idle; not enforced.
// top level of the envelope block; depends on lae_pkg, lae_ifs, lae_cfg_regs
// and lae_core
module linear_adsr_envelope #(
    parameter int LEVEL_FRAC_BITS = lae_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lae_in_if.sink     i_in,
    lae_out_if.source  o_out,
    lae_cfg_if.sink    i_cfg
);
    import lae_pkg::*;

    t_cfg      cfg;
    t_in_item  in_item;
    t_out_item out_item;

    assign in_item.opcode = i_in.opcode;
    assign in_item.stop   = i_in.stop;
    assign o_out.level    = out_item.level;
    assign o_out.active   = out_item.active;

    lae_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    lae_core #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in.valid),
        .i_in_item   (in_item),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );

`ifndef SYNTH
    // idle envelope always reports zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.active) |-> (o_out.level == '0))
        else $error("idle result with non-zero level");

    // input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a pending result");

    // an item taken while no result is held yields a result via the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !o_out.valid) |=> ##1 o_out.valid)
        else $error("result missing after accepted transaction");
`endif

endmodule

[hw/rtl/lae_cfg_regs.sv]
// configuration register file of the envelope block
// depends on lae_pkg
module lae_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_valid,
    input  logic [lae_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [lae_pkg::CFG_STEP_W-1:0] i_wr_data,
    output logic                          o_wr_ready,
    output lae_pkg::t_cfg                 o_cfg
);
    import lae_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            case (i_wr_index)
                REG_ATTACK_STEP:  n_cfg.attack_step  = i_wr_data;
                REG_DECAY_STEP:   n_cfg.decay_step   = i_wr_data;
                REG_RELEASE_STEP: n_cfg.release_step = i_wr_data;
                REG_HOLD_LEVEL:   n_cfg.hold_level   = i_wr_data;
                REG_START_MODE:   n_cfg.start_mode   = i_wr_data[CFG_MODE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step  <= RST_ATTACK_STEP;
            r_cfg.decay_step   <= RST_DECAY_STEP;
            r_cfg.release_step <= RST_RELEASE_STEP;
            r_cfg.hold_level   <= RST_HOLD_LEVEL;
            r_cfg.start_mode   <= RST_START_MODE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hw/rtl/lae_core.sv]
// envelope datapath: input register, phase and level state, result register
// depends on lae_pkg
module lae_core #(
    parameter int LEVEL_FRAC_BITS = lae_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lae_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    input  lae_pkg::t_in_item  i_in_item,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lae_pkg::t_out_item o_out_item
);
    import lae_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int AW = ((LW > CFG_STEP_W) ? LW : CFG_STEP_W) + 1;
    localparam logic [AW-1:0] ONE = AW'(1) << LEVEL_FRAC_BITS;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_phase    r_phase;
    logic [LW-1:0] r_level;

    t_phase        n_phase;
    t_phase        cur_phase;
    logic [AW-1:0] n_level;
    logic [AW-1:0] lvl;
    logic [AW-1:0] att;
    logic [AW-1:0] dec;
    logic [AW-1:0] rel;
    logic [AW-1:0] sus_raw;
    logic [AW-1:0] sus;
    logic          advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign lvl     = AW'(r_level);
    assign att     = AW'(i_cfg.attack_step);
    assign dec     = AW'(i_cfg.decay_step);
    assign rel     = AW'(i_cfg.release_step);
    assign sus_raw = AW'(i_cfg.hold_level);
    assign sus     = (sus_raw > ONE) ? ONE : sus_raw;

    always_comb begin
        n_phase   = r_phase;
        n_level   = lvl;
        cur_phase = r_phase;
        if (r_in_item.opcode) begin
            case (i_cfg.start_mode)
                START_NORMAL: begin
                    n_level = '0;
                    n_phase = PH_ATTACK;
                end
                START_SKIP_ATTACK: begin
                    n_level = ONE;
                    n_phase = PH_DECAY;
                end
                default: begin
                    n_level = sus;
                    n_phase = PH_SUSTAIN;
                end
            endcase
        end else begin
            if (r_in_item.stop) begin
                cur_phase = PH_RELEASE;
            end
            n_phase = cur_phase;
            case (cur_phase)
                PH_ATTACK: begin
                    if (lvl + att >= ONE) begin
                        n_level = ONE;
                        n_phase = PH_DECAY;
                    end else begin
                        n_level = lvl + att;
                    end
                end
                PH_DECAY: begin
                    if (lvl <= sus + dec) begin
                        n_level = sus;
                        n_phase = PH_SUSTAIN;
                    end else begin
                        n_level = lvl - dec;
                    end
                end
                PH_SUSTAIN: begin
                    n_level = sus;
                end
                PH_RELEASE: begin
                    if (lvl <= rel) begin
                        n_level = '0;
                        n_phase = PH_IDLE;
                    end else begin
                        n_level = lvl - rel;
                    end
                end
                default: begin
                    n_level = '0;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_level     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_level     <= n_level[LW-1:0];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item.level  <= n_level[IO_LEVEL_W-1:0];
            r_out_item.active <= (n_phase != PH_IDLE);
        end
    end

endmodule

[dv/lae_tb_pkg.sv]
`timescale 1ns / 100ps
// opcodes, spare start modes, spare register codes and level constants used by the envelope testbench
// depends on lae_pkg
package lae_tb_pkg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [lae_pkg::CFG_MODE_W-1:0] START_SKIP_BOTH  = 2'd2;
    localparam logic [lae_pkg::CFG_MODE_W-1:0] START_MODE_SPARE = 2'd3;

    localparam logic [lae_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;

    localparam logic [lae_pkg::CFG_STEP_W-1:0] LEVEL_ONE = 25'h1000000;
    localparam logic [lae_pkg::CFG_STEP_W-1:0] LEVEL_MAX = 25'h1FFFFFF;

endpackage

[dv/lae_checker.sv]
`timescale 1ns / 100ps
// envelope checker: tracks register writes, predicts each level transaction and compares
// depends on lae_pkg, lae_tb_pkg and the channel interfaces
module lae_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lae_in_if    i_in_mon,
    lae_out_if   i_out_mon,
    lae_cfg_if   i_cfg_mon,
    output int   o_errors,
    output int   o_pending
);
    import lae_pkg::*;
    import lae_tb_pkg::*;

    localparam logic [25:0] FULL_SCALE = 26'd1 << LEVEL_FRAC_BITS_DEF;

    t_cfg        env_regs;
    t_phase      env_phase;
    logic [25:0] env_level;
    t_out_item   expected_levels [$];
    int          fail_count = 0;

    assign o_errors = fail_count;

    function automatic t_out_item next_envelope(input t_in_item item);
        logic [25:0] sus;
        t_out_item   res;
        sus = (env_regs.hold_level > FULL_SCALE) ? FULL_SCALE
                                                 : {1'b0, env_regs.hold_level};
        if (item.opcode == OP_START) begin
            case (env_regs.start_mode)
                START_NORMAL: begin
                    env_level = '0;
                    env_phase = PH_ATTACK;
                end
                START_SKIP_ATTACK: begin
                    env_level = FULL_SCALE;
                    env_phase = PH_DECAY;
                end
                default: begin
                    env_level = sus;
                    env_phase = PH_SUSTAIN;
                end
            endcase
        end else begin
            if (item.stop)
                env_phase = PH_RELEASE;
            case (env_phase)
                PH_ATTACK: begin
                    if (env_level + env_regs.attack_step >= FULL_SCALE) begin
                        env_level = FULL_SCALE;
                        env_phase = PH_DECAY;
                    end else begin
                        env_level = env_level + env_regs.attack_step;
                    end
                end
                PH_DECAY: begin
                    if (env_level <= sus + env_regs.decay_step) begin
                        env_level = sus;
                        env_phase = PH_SUSTAIN;
                    end else begin
                        env_level = env_level - env_regs.decay_step;
                    end
                end
                PH_SUSTAIN: env_level = sus;
                PH_RELEASE: begin
                    if (env_level <= {1'b0, env_regs.release_step}) begin
                        env_level = '0;
                        env_phase = PH_IDLE;
                    end else begin
                        env_level = env_level - env_regs.release_step;
                    end
                end
                default: begin
                    env_level = '0;
                    env_phase = PH_IDLE;
                end
            endcase
        end
        res.level  = env_level[IO_LEVEL_W-1:0];
        res.active = (env_phase != PH_IDLE);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_in_item  item;
        t_out_item want;
        if (!i_rst_n) begin
            env_regs.attack_step  = RST_ATTACK_STEP;
            env_regs.decay_step   = RST_DECAY_STEP;
            env_regs.release_step = RST_RELEASE_STEP;
            env_regs.hold_level   = RST_HOLD_LEVEL;
            env_regs.start_mode   = RST_START_MODE;
            env_phase             = PH_IDLE;
            env_level             = '0;
            expected_levels.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    REG_ATTACK_STEP:  env_regs.attack_step  = i_cfg_mon.data;
                    REG_DECAY_STEP:   env_regs.decay_step   = i_cfg_mon.data;
                    REG_RELEASE_STEP: env_regs.release_step = i_cfg_mon.data;
                    REG_HOLD_LEVEL:   env_regs.hold_level   = i_cfg_mon.data;
                    REG_START_MODE:   env_regs.start_mode   = i_cfg_mon.data[CFG_MODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                item.opcode = i_in_mon.opcode;
                item.stop   = i_in_mon.stop;
                expected_levels.push_back(next_envelope(item));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_levels.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected transaction, level %h active %b",
                             $realtime, i_out_mon.level, i_out_mon.active);
                end else begin
                    want = expected_levels.pop_front();
                    if (i_out_mon.level !== want.level) begin
                        fail_count++;
                        $display("%0t: level expected %h actual %h",
                                 $realtime, want.level, i_out_mon.level);
                    end
                    if (i_out_mon.active !== want.active) begin
                        fail_count++;
                        $display("%0t: active expected %b actual %b",
                                 $realtime, want.active, i_out_mon.active);
                    end
                end
            end
        end
        o_pending <= expected_levels.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// top of the envelope testbench: clock, reset, command and register stimulus, verdict
// depends on lae_pkg, lae_tb_pkg, the channel interfaces, lae_checker and the block
module testbench;
    import lae_pkg::*;
    import lae_tb_pkg::*;

    localparam int ITEM_TARGET = 2000;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   items_sent   = 0;
    int   burst_left   = 0;
    bit   tight        = 1'b0;
    int   holds_asked  = 0;
    bit   pressure_done = 1'b0;

    lae_in_if  in_ch ();
    lae_out_if out_ch ();
    lae_cfg_if cfg_ch ();

    linear_adsr_envelope u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lae_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in_mon  (in_ch),
        .i_out_mon (out_ch),
        .i_cfg_mon (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #1 clk = ~clk;

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: stall segments, occasional long hold-offs, and holds on request
    initial begin
        int hold_left;
        int seg_left;
        int stall_pct;
        int holds_served;
        hold_left    = 0;
        seg_left     = 0;
        stall_pct    = 0;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = 80;
                out_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 200);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    if ($urandom_range(0, 19) == 0)
                        hold_left = $urandom_range(40, 100);
                end else begin
                    seg_left--;
                end
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_item(input logic opcode, input logic stop);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!tight && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 7);
        end
        burst_left--;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= opcode;
        in_ch.stop   <= stop;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic drain_levels();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_regs(input logic [CFG_STEP_W-1:0] atk, input logic [CFG_STEP_W-1:0] dcy,
                             input logic [CFG_STEP_W-1:0] rls, input logic [CFG_STEP_W-1:0] sus,
                             input logic [CFG_MODE_W-1:0] mode);
        logic [CFG_IDX_W-1:0]  idx_seq [6];
        logic [CFG_STEP_W-1:0] val_seq [6];
        idx_seq = '{REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), REG_ATTACK_STEP,
                    REG_DECAY_STEP, REG_RELEASE_STEP, REG_HOLD_LEVEL, REG_START_MODE};
        val_seq = '{CFG_STEP_W'($urandom), atk, dcy, rls, sus, {23'($urandom), mode}};
        for (int k = 0; k < 6; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx_seq[k];
            cfg_ch.data  <= val_seq[k];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CFG_STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_STEP_W'($urandom_range(1, 16));
            2:       return LEVEL_ONE;
            3:       return CFG_STEP_W'($urandom_range(16777217, 33554431));
            default: return CFG_STEP_W'($urandom_range(349525, 16777216));
        endcase
    endfunction

    function automatic logic [CFG_STEP_W-1:0] pick_sustain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LEVEL_ONE;
            2:       return CFG_STEP_W'($urandom_range(16777217, 33554431));
            default: return CFG_STEP_W'($urandom_range(0, 16777216));
        endcase
    endfunction

    // start, hold for a while, release, let the tail run out
    task automatic play_note();
        int hold_ticks;
        int tail_ticks;
        hold_ticks = $urandom_range(0, 40);
        tail_ticks = $urandom_range(0, 24);
        send_item(OP_START, 1'($urandom));
        repeat (hold_ticks) send_item(OP_TICK, $urandom_range(0, 29) == 0);
        send_item(OP_TICK, 1'b1);
        repeat (tail_ticks) send_item(OP_TICK, 1'b0);
    endtask

    initial begin
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_TICK;
        in_ch.stop   <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_ATTACK_STEP;
        cfg_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stop while idle, full cycle through every phase
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_START, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);

        // skip attack, sustain above one, zero release step
        drain_levels();
        load_regs(LEVEL_MAX, 25'h0400000, '0, LEVEL_MAX, START_SKIP_ATTACK);
        send_item(OP_START, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);

        // skip both at zero sustain
        drain_levels();
        load_regs(LEVEL_ONE, LEVEL_ONE, 25'd1, '0, START_SKIP_BOTH);
        send_item(OP_START, 1'b0);
        send_item(OP_TICK, 1'b1);

        // spare start mode behaves as skip both
        drain_levels();
        load_regs(LEVEL_ONE, LEVEL_ONE, 25'd1, LEVEL_ONE, START_MODE_SPARE);
        send_item(OP_START, 1'b1);
        send_item(OP_TICK, 1'b1);

        // sustain raised above the level mid decay
        drain_levels();
        load_regs(LEVEL_ONE, 25'h0400000, LEVEL_ONE, '0, START_SKIP_ATTACK);
        send_item(OP_START, 1'b0);
        send_item(OP_TICK, 1'b0);
        drain_levels();
        load_regs(LEVEL_ONE, 25'h0400000, LEVEL_ONE, 25'h0FFFFFF, START_SKIP_ATTACK);
        send_item(OP_TICK, 1'b0);

        // zero attack step holds, smallest step creeps
        drain_levels();
        load_regs('0, '0, LEVEL_ONE, 25'h0800000, START_NORMAL);
        send_item(OP_START, 1'b0);
        send_item(OP_TICK, 1'b0);
        drain_levels();
        load_regs(25'd1, '0, LEVEL_ONE, 25'h0800000, START_NORMAL);
        send_item(OP_TICK, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            drain_levels();
            tight = ($urandom_range(0, 3) == 0);
            load_regs(pick_step(), pick_step(), pick_step(), pick_sustain(),
                      CFG_MODE_W'($urandom_range(0, 3)));
            if (!pressure_done) begin
                pressure_done = 1'b1;
                tight         = 1'b1;
                holds_asked++;
            end
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 5)) send_item(1'($urandom), 1'($urandom));
                play_note();
            end
        end

        drain_levels();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
